@@ hw/rtl/ffia_pkg.sv @@
// Shared types and constants for the first-fit interval allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ffia_pkg;

  localparam int PREF_W = 31;
  localparam int DUR_W  = 24;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] TIME_ONE = 32'd1;
  localparam logic [TIME_W-1:0] TIME_TOP = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREF,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ffia_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the request, clear the search
    logic issue_pref;  // push the preferred start into the fit pipeline
    logic issue_cand;  // push the next stored candidate into the fit pipeline
    logic finish;      // decide, update the tables, drive the result
  } ffia_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;        // interval table holds its maximum
    logic last_cand;   // next candidate issued is the final one
    logic pipe_busy;   // fit pipeline still holds items
  } ffia_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffia_ctrl.sv @@
// Sequencer of the interval allocator: load, preferred check, candidate scan,
// pipeline drain and commit. Uses ffia_pkg for its state, command and status types.
`default_nettype none

module ffia_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire ffia_pkg::ffia_stat_t stat,
  output ffia_pkg::ffia_cmd_t    cmd
);
  import ffia_pkg::*;

  ffia_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_PREF;
      end
      ST_PREF: begin
        // a full table skips the search entirely
        state_nxt = stat.full ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.last_cand) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_PREF: begin
        cmd.issue_pref = !stat.full;
      end
      ST_SCAN: begin
        cmd.issue_cand = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ffia_datapath.sv @@
// Datapath of the interval allocator: granted-interval cells, candidate memory,
// three-stage fit pipeline and result registers. Uses ffia_pkg.
`default_nettype none

module ffia_datapath #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire ffia_pkg::ffia_cmd_t       cmd,
  output ffia_pkg::ffia_stat_t           stat,
  input  wire [ffia_pkg::PREF_W-1:0]     in_preferred_start,
  input  wire [ffia_pkg::DUR_W-1:0]      in_duration,
  output logic                           out_valid,
  output logic [ffia_pkg::TIME_W-1:0]    out_granted_start,
  output logic [ffia_pkg::TIME_W-1:0]    out_granted_end,
  output logic                           out_was_moved,
  output logic                           out_table_full
);
  import ffia_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);      // interval index
  localparam int AW = $clog2(MAX_ENTRIES + 1);  // interval count, candidate index
  localparam int CW = $clog2(MAX_ENTRIES + 2);  // candidate count
  localparam int CD = MAX_ENTRIES + 1;          // candidate depth

  // granted intervals, one comparator cell each
  logic [TIME_W-1:0] ifirst_r [MAX_ENTRIES];
  logic [TIME_W-1:0] ilast_r  [MAX_ENTRIES];
  logic [AW-1:0]     icount_r;

  // candidate starts; entry zero is the constant 1 and is never written
  logic [TIME_W-1:0] cand_mem [CD];
  logic [TIME_W-1:0] rd_data_r;
  logic [CW-1:0]     ccount_r;
  logic [CW-1:0]     idx_r;

  // request
  logic [TIME_W-1:0] pref_r;
  logic [DUR_W-1:0]  dur_r;

  // fit pipeline
  logic              s1_v_r, s1_pref_r, s1_zero_r;
  logic              s2_v_r, s2_pref_r;
  logic [TIME_W-1:0] s2_c_r;
  logic [TIME_W:0]   s2_e_r;
  logic              s3_v_r, s3_pref_r, s3_fit_r;
  logic [TIME_W-1:0] s3_c_r, s3_e_r;
  logic [TIME_W-1:0] s1_c;
  logic              hit_any;

  // search outcome
  logic              pref_fit_r, found_r;
  logic [TIME_W-1:0] pref_end_r, best_c_r, best_e_r;

  logic              full;
  logic              grant_ok;
  logic [TIME_W-1:0] g_start, g_end;
  logic              grant_we;

  assign full           = (icount_r == AW'(MAX_ENTRIES));
  assign stat.full      = full;
  assign stat.last_cand = (idx_r == ccount_r - CW'(1));
  assign stat.pipe_busy = s1_v_r | s2_v_r | s3_v_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pref_r <= (in_preferred_start == '0) ? TIME_ONE : {1'b0, in_preferred_start};
      dur_r  <= (in_duration == '0) ? DUR_W'(1) : in_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.issue_cand) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // stage 1: candidate read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue_pref | cmd.issue_cand;
    end
  end

  always_ff @(posedge clk) begin
    s1_pref_r <= cmd.issue_pref;
    s1_zero_r <= (idx_r == '0);
  end

  always_ff @(posedge clk) begin
    if (grant_we && g_end != TIME_TOP) begin
      cand_mem[ccount_r[AW-1:0]] <= g_end + TIME_ONE;
    end
    if (cmd.issue_cand) begin
      rd_data_r <= cand_mem[idx_r[AW-1:0]];
    end
  end

  assign s1_c = s1_pref_r ? pref_r : (s1_zero_r ? TIME_ONE : rd_data_r);

  // stage 2: end of the trial interval, one bit wider to catch running off the time line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_pref_r <= s1_pref_r;
    s2_c_r    <= s1_c;
    s2_e_r    <= {1'b0, s1_c} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur_r} - (TIME_W + 1)'(1);
  end

  // stage 3: compare against every live interval cell
  always_comb begin
    hit_any = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (AW'(i) < icount_r && s2_c_r <= ilast_r[i] && ifirst_r[i] <= s2_e_r[TIME_W-1:0]) begin
        hit_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_pref_r <= s2_pref_r;
    s3_c_r    <= s2_c_r;
    s3_e_r    <= s2_e_r[TIME_W-1:0];
    s3_fit_r  <= !s2_e_r[TIME_W] && !hit_any;
  end

  // keep the preferred verdict and the smallest fitting candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_fit_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.load) begin
      pref_fit_r <= 1'b0;
      found_r    <= 1'b0;
    end else if (s3_v_r) begin
      if (s3_pref_r) begin
        pref_fit_r <= s3_fit_r;
      end else if (s3_fit_r && (!found_r || s3_c_r < best_c_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      if (s3_pref_r) begin
        pref_end_r <= s3_e_r;
      end else if (s3_fit_r && (!found_r || s3_c_r < best_c_r)) begin
        best_c_r <= s3_c_r;
        best_e_r <= s3_e_r;
      end
    end
  end

  // commit
  assign grant_ok = !full && (pref_fit_r || found_r);
  assign g_start  = pref_fit_r ? pref_r : best_c_r;
  assign g_end    = pref_fit_r ? pref_end_r : best_e_r;
  assign grant_we = cmd.finish && grant_ok;

  always_ff @(posedge clk) begin
    if (grant_we) begin
      ifirst_r[icount_r[IW-1:0]] <= g_start;
      ilast_r[icount_r[IW-1:0]]  <= g_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icount_r <= '0;
      ccount_r <= CW'(1);
    end else if (grant_we) begin
      icount_r <= icount_r + AW'(1);
      // a grant ending at the top of the time line adds no candidate
      if (g_end != TIME_TOP) ccount_r <= ccount_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (full) begin
        out_granted_start <= '0;
        out_granted_end   <= '0;
        out_was_moved     <= 1'b0;
        out_table_full    <= 1'b1;
      end else if (grant_ok) begin
        out_granted_start <= g_start;
        out_granted_end   <= g_end;
        out_was_moved     <= (g_start != pref_r);
        out_table_full    <= 1'b0;
      end else begin
        out_granted_start <= '0;
        out_granted_end   <= '0;
        out_was_moved     <= 1'b0;
        out_table_full    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_interval_allocator_core.sv @@
// Top level of the first-fit interval allocator: controller plus datapath.
// Depends on ffia_pkg, ffia_ctrl and ffia_datapath.
`default_nettype none

// A request is taken when start is high and busy is low. It first tries the
// preferred start, then every stored candidate start (time 1 and one past each
// grant's end), one candidate per cycle through a three-stage fit pipeline that
// compares it with all granted intervals at once. The time from acceptance to
// the result grows with the number of stored candidates, since the candidate
// scan sets it; a full table skips the search. The result sits on the out_
// ports for exactly one cycle with out_valid high and must be captured then:
// there is no way to stall it. A new request may be started in the cycle the
// result is shown.
module first_fit_interval_allocator_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire [ffia_pkg::PREF_W-1:0]     in_preferred_start,
  input  wire [ffia_pkg::DUR_W-1:0]      in_duration,
  output logic                           out_valid,
  output logic [ffia_pkg::TIME_W-1:0]    out_granted_start,
  output logic [ffia_pkg::TIME_W-1:0]    out_granted_end,
  output logic                           out_was_moved,
  output logic                           out_table_full
);
  import ffia_pkg::*;

  ffia_cmd_t  cmd;
  ffia_stat_t stat;

  ffia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffia_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_preferred_start (in_preferred_start),
    .in_duration        (in_duration),
    .out_valid          (out_valid),
    .out_granted_start  (out_granted_start),
    .out_granted_end    (out_granted_end),
    .out_was_moved      (out_was_moved),
    .out_table_full     (out_table_full)
  );

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_full_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (out_granted_start == '0 && out_granted_end == '0 && !out_was_moved))
    else $error("table-full result carries a grant");

  a_grant_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted_start != '0) |-> (out_granted_end >= out_granted_start))
    else $error("grant ends before it starts");
`endif

endmodule

`default_nettype wire

@@ tb/grant_checker_pkg.sv @@
`timescale 1ns / 100ps
// Grant predictor and checker for the first-fit interval allocator testbench.
// Self-contained; imported by tb_top, which feeds it accepted items and results.
package grant_checker_pkg;

  localparam int SLOTS = 64;
  localparam longint unsigned LINE_TOP = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
    logic        moved;
    logic        full;
  } grant_t;

  class grant_checker;
    logic [31:0] iv_first [SLOTS];
    logic [31:0] iv_last  [SLOTS];
    logic [31:0] cand_time [SLOTS+1];
    int unsigned iv_count;
    int unsigned cand_count;
    grant_t      grant_q [$];
    int unsigned mismatches;

    function new();
      iv_count     = 0;
      cand_count   = 1;
      cand_time[0] = 32'd1;
      mismatches   = 0;
    endfunction

    function bit span_free(longint unsigned lo, longint unsigned hi);
      for (int i = 0; i < iv_count; i++) begin
        if (lo <= longint'(iv_last[i]) && longint'(iv_first[i]) <= hi) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Work out the grant for one item and update the tables as the block does.
    function grant_t predict_grant(logic [30:0] pref_in, logic [23:0] dur_in);
      longint unsigned pref, dur, first, last, c, e, nxt;
      bit     found, dup;
      grant_t g;
      pref  = longint'(pref_in);
      dur   = longint'(dur_in);
      first = 0;
      last  = 0;
      found = 1'b0;
      g     = '0;
      if (pref == 0) pref = 1;
      if (dur == 0) dur = 1;
      if (iv_count >= SLOTS) begin
        g.full = 1'b1;
        return g;
      end
      if (span_free(pref, pref + dur - 1)) begin
        first = pref;
        last  = pref + dur - 1;
        found = 1'b1;
      end else begin
        for (int i = 0; i < cand_count; i++) begin
          c = longint'(cand_time[i]);
          e = c + dur - 1;
          if (e > LINE_TOP) continue;
          if (found && c >= first) continue;
          if (span_free(c, e)) begin
            first = c;
            last  = e;
            found = 1'b1;
          end
        end
      end
      // no candidate fits: refuse with all fields zero
      if (!found) return g;
      iv_first[iv_count] = first[31:0];
      iv_last[iv_count]  = last[31:0];
      iv_count++;
      nxt = last + 1;
      if (nxt <= LINE_TOP) begin
        dup = 1'b0;
        for (int i = 0; i < cand_count; i++) begin
          if (longint'(cand_time[i]) == nxt) dup = 1'b1;
        end
        if (!dup && cand_count < SLOTS + 1) begin
          cand_time[cand_count] = nxt[31:0];
          cand_count++;
        end
      end
      g.first = first[31:0];
      g.last  = last[31:0];
      g.moved = (first != pref);
      return g;
    endfunction

    function void note_request(logic [30:0] pref, logic [23:0] dur);
      grant_q = {grant_q, predict_grant(pref, dur)};
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_grant(logic [31:0] first, logic [31:0] last, logic moved, logic full);
      grant_t want;
      if (grant_q.size() == 0) begin
        report_mismatch($sformatf("grant %0d..%0d with no item pending", first, last));
        return;
      end
      want = grant_q.pop_front();
      if (first !== want.first)
        report_mismatch($sformatf("granted_start %0d, want %0d", first, want.first));
      if (last !== want.last)
        report_mismatch($sformatf("granted_end %0d, want %0d", last, want.last));
      if (moved !== want.moved)
        report_mismatch($sformatf("was_moved %b, want %b", moved, want.moved));
      if (full !== want.full)
        report_mismatch($sformatf("table_full %b, want %b", full, want.full));
    endtask
  endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the first-fit interval allocator testbench: clock, reset, item driver,
// result monitor and watchdog. Depends on ffia_pkg, grant_checker_pkg and the core.
module tb_top;
  import grant_checker_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 80;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [ffia_pkg::PREF_W-1:0]  in_preferred_start;
  logic [ffia_pkg::DUR_W-1:0]   in_duration;
  logic                         out_valid;
  logic [ffia_pkg::TIME_W-1:0]  out_granted_start;
  logic [ffia_pkg::TIME_W-1:0]  out_granted_end;
  logic                         out_was_moved;
  logic                         out_table_full;

  grant_checker sb;

  first_fit_interval_allocator_core #(
    .MAX_ENTRIES(SLOTS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_preferred_start(in_preferred_start),
    .in_duration       (in_duration),
    .out_valid         (out_valid),
    .out_granted_start (out_granted_start),
    .out_granted_end   (out_granted_end),
    .out_was_moved     (out_was_moved),
    .out_table_full    (out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results first: one shown this cycle belongs to an item taken earlier.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_grant(out_granted_start, out_granted_end, out_was_moved, out_table_full);
      if (start && !busy)
        sb.note_request(in_preferred_start, in_duration);
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall = 0;
      else stall++;
    end
    $display("** first_fit_interval_allocator_core: FAILED **");
    $finish;
  end

  // Hold start high until the item is taken.
  task automatic send_request(input logic [30:0] pref, input logic [23:0] dur);
    @(negedge clk);
    start              <= 1'b1;
    in_preferred_start <= pref;
    in_duration        <= dur;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_grants();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly crowded low windows so grants collide and the candidate scan runs;
  // the rest spans the full field ranges.
  task automatic pick_request(output logic [30:0] pref, output logic [23:0] dur);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      pref = 31'($urandom_range(0, 3000));
      dur  = 24'($urandom_range(0, 400));
    end else if (mode < 7) begin
      pref = 31'($urandom_range(0, 200));
      dur  = 24'($urandom_range(1, 5000));
    end else begin
      pref = 31'($urandom);
      dur  = 24'($urandom);
    end
  endtask

  initial begin : stimulus
    logic [30:0] pref;
    logic [23:0] dur;
    int          sent;
    int          burst;

    sb                 = new();
    rst_n              = 1'b0;
    start              = 1'b0;
    in_preferred_start = '0;
    in_duration        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, zero start and duration, touching and moved grants
    send_request(31'd1, 24'd1);
    send_request(31'd0, 24'd0);
    send_request(31'h7FFF_FFFF, 24'hFF_FFFF);
    send_request(31'd5, 24'd0);
    send_request(31'd3, 24'd5);
    send_request(31'd10, 24'd2);
    send_request(31'd11, 24'd1);
    hold_off(3);
    send_request(31'h7FFF_FFFF, 24'd1);
    send_request(31'h4000_0000, 24'h80_0000);
    send_request(31'h4000_0000, 24'd1);
    send_request(31'd1, 24'hFF_FFFF);
    send_request(31'h2AAA_AAAA, 24'hAA_AAAA);
    send_request(31'h5555_5555, 24'h55_5555);
    send_request(31'd0, 24'hFF_FFFF);
    drain_grants();

    // random bursts; the table fills early and later items check refusal
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        pick_request(pref, dur);
        send_request(pref, dur);
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_grants();
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 90));
    end

    drain_grants();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** first_fit_interval_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_interval_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ffia_pkg.sv
hw/rtl/ffia_ctrl.sv
hw/rtl/ffia_datapath.sv
hw/rtl/first_fit_interval_allocator_core.sv
tb/grant_checker_pkg.sv
tb/tb_top.sv
